/* rtl/core/ssrm_pkg.sv */
// ----------------------------------------------------------------------------
// ssrm_pkg: stream sequence and rate monitor shared definitions
// Beat types, event and command codes, snapshot slot indexes and defaults.
// ----------------------------------------------------------------------------
package ssrm_pkg;

    // Defaults for the top-level parameters
    localparam int COUNTER_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Event codes on the input mode field
    localparam logic [2:0] MODE_SRC_SEQ  = 3'd0;
    localparam logic [2:0] MODE_SRC      = 3'd1;
    localparam logic [2:0] MODE_PUB_OK   = 3'd2;
    localparam logic [2:0] MODE_PUB_AUX  = 3'd3;
    localparam logic [2:0] MODE_DROP     = 3'd4;
    localparam logic [2:0] MODE_PUB_FAIL = 3'd5;
    localparam logic [2:0] MODE_SNAP     = 3'd6;

    // Sequence width modes
    localparam logic [1:0] WM_NONE = 2'd0;
    localparam logic [1:0] WM_32   = 2'd1;
    localparam logic [1:0] WM_64   = 2'd2;

    // Half of the 32-bit range, used for wrap detection
    localparam logic [31:0] HALF32 = 32'h7FFF_FFFF;

    // Event counters and snapshot slots
    localparam int NUM_CNT = 11;
    localparam logic [3:0] CNT_SRC      = 4'd0;
    localparam logic [3:0] CNT_PUB      = 4'd1;
    localparam logic [3:0] CNT_AUX      = 4'd2;
    localparam logic [3:0] CNT_DROP     = 4'd3;
    localparam logic [3:0] CNT_FAIL     = 4'd4;
    localparam logic [3:0] CNT_SEQ_GAP  = 4'd5;
    localparam logic [3:0] CNT_SEQ_DUP  = 4'd6;
    localparam logic [3:0] CNT_SEQ_REG  = 4'd7;
    localparam logic [3:0] CNT_TS_DUP   = 4'd8;
    localparam logic [3:0] CNT_TS_REG   = 4'd9;
    localparam logic [3:0] CNT_LAT      = 4'd10;
    localparam logic [3:0] IDX_LAT_SUM  = 4'd11;
    localparam logic [3:0] IDX_LAT_MAX  = 4'd12;
    localparam logic [3:0] IDX_START    = 4'd13;
    localparam logic [3:0] IDX_END      = 4'd14;

    // Commands passed from the front to the back
    typedef enum logic [2:0] {
        OP_SRC  = 3'd0,
        OP_PUB  = 3'd1,
        OP_AUX  = 3'd2,
        OP_DROP = 3'd3,
        OP_FAIL = 3'd4,
        OP_SNAP = 3'd5
    } t_op;

    // Input beat
    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] seq_number;
        logic [63:0] sample_time_ns;
        logic [63:0] mono_time_ns;
        logic [63:0] pub_latency;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [3:0]  counter_index;
        logic [63:0] counter_value;
        logic        last_item;
    } t_out;

    // Queued command: arg is latency for successful publishes, mono time otherwise
    typedef struct packed {
        t_op         op;
        logic        has_seq;
        logic [1:0]  wmode;
        logic [63:0] seq;
        logic        seq_lt_half;
        logic [63:0] ts;
        logic [63:0] arg;
    } t_cmd;

endpackage

/* rtl/core/ssrm_front.sv */
// ----------------------------------------------------------------------------
// ssrm_front: event intake and decode
// Holds the width mode register, accepts input beats, decodes the event and
// trims the sequence number, then pushes a command into the queue.
// ----------------------------------------------------------------------------
module ssrm_front
    import ssrm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in        i_in_data,
    output logic       o_in_stall,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [1:0] r_wmode;
    logic [1:0] wmode_norm;
    logic       accept;
    logic       known;
    t_cmd       cmd;

    // Hold the sequence width mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmode <= WM_NONE;
        end else if (i_cfg_we) begin
            r_wmode <= i_cfg_wdata;
        end
    end

    // Fold the unused code onto no checking
    assign wmode_norm = (r_wmode inside {WM_32, WM_64}) ? r_wmode : WM_NONE;

    // Decode the event into a command
    always_comb begin
        known           = 1'b1;
        cmd.op          = OP_SRC;
        cmd.has_seq     = 1'b0;
        cmd.wmode       = wmode_norm;
        cmd.seq         = (wmode_norm == WM_32) ? {32'b0, i_in_data.seq_number[31:0]}
                                                : i_in_data.seq_number;
        cmd.seq_lt_half = (i_in_data.seq_number[31:0] < HALF32);
        cmd.ts          = i_in_data.sample_time_ns;
        cmd.arg         = i_in_data.mono_time_ns;
        case (i_in_data.mode)
            MODE_SRC_SEQ: begin
                cmd.has_seq = 1'b1;
            end
            MODE_SRC: begin
                cmd.op = OP_SRC;
            end
            MODE_PUB_OK: begin
                cmd.op  = OP_PUB;
                cmd.arg = i_in_data.pub_latency;
            end
            MODE_PUB_AUX: begin
                cmd.op = OP_AUX;
            end
            MODE_DROP: begin
                cmd.op = OP_DROP;
            end
            MODE_PUB_FAIL: begin
                cmd.op = OP_FAIL;
            end
            MODE_SNAP: begin
                cmd.op = OP_SNAP;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Stall while the queue is full; drop unknown events
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept && known;
    assign o_cmd      = cmd;

endmodule

/* rtl/core/ssrm_queue.sv */
// ----------------------------------------------------------------------------
// ssrm_queue: command queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module ssrm_queue
    import ssrm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/ssrm_back.sv */
// ----------------------------------------------------------------------------
// ssrm_back: monitor state and snapshot drain
// Executes queued commands against the counters and history, and streams a
// snapshot through the output register one beat at a time.
// ----------------------------------------------------------------------------
module ssrm_back
    import ssrm_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_bstate;

    t_bstate                 r_state;
    logic [COUNTER_BITS-1:0] r_cnt [NUM_CNT];
    logic [63:0]             r_lat_sum;
    logic [63:0]             r_lat_max;
    logic [63:0]             r_first_mono;
    logic [63:0]             r_prev_seq;
    logic [63:0]             r_prev_inc;
    logic                    r_seq_seen;
    logic [63:0]             r_prev_ts;
    logic                    r_ts_seen;
    logic [63:0]             r_end_time;
    logic [3:0]              r_slot;
    logic                    r_out_valid;
    t_out                    r_out;

    logic               pop;
    logic               is_src;
    logic               seq_check;
    logic [63:0]        expect_seq;
    logic               wrapped;
    logic               seq_gap;
    logic [NUM_CNT-1:0] inc;
    logic               out_free;
    logic [63:0]        slot_value;

    assign pop    = i_q_valid && (r_state == ST_IDLE);
    assign o_pop  = pop;
    assign is_src = pop && (i_cmd.op == OP_SRC);

    // Classify the sequence number against the expected successor
    assign seq_check  = is_src && i_cmd.has_seq && (i_cmd.wmode != WM_NONE) && r_seq_seen;
    assign expect_seq = (i_cmd.wmode == WM_32) ? {32'b0, r_prev_inc[31:0]} : r_prev_inc;
    assign wrapped    = (i_cmd.wmode == WM_32) && (r_prev_seq > 64'(HALF32))
                        && i_cmd.seq_lt_half;
    assign seq_gap    = (i_cmd.seq > expect_seq) || wrapped;

    // Select counter increments
    always_comb begin
        inc = '0;
        if (pop) begin
            case (i_cmd.op)
                OP_SRC: begin
                    inc[CNT_SRC] = 1'b1;
                    if (seq_check) begin
                        if (i_cmd.seq == r_prev_seq) begin
                            inc[CNT_SEQ_DUP] = 1'b1;
                        end else if (i_cmd.seq != expect_seq) begin
                            if (seq_gap) begin
                                inc[CNT_SEQ_GAP] = 1'b1;
                            end else begin
                                inc[CNT_SEQ_REG] = 1'b1;
                            end
                        end
                    end
                    if (r_ts_seen) begin
                        if (i_cmd.ts == r_prev_ts) begin
                            inc[CNT_TS_DUP] = 1'b1;
                        end else if (i_cmd.ts < r_prev_ts) begin
                            inc[CNT_TS_REG] = 1'b1;
                        end
                    end
                end
                OP_PUB: begin
                    inc[CNT_PUB] = 1'b1;
                    inc[CNT_LAT] = 1'b1;
                end
                OP_AUX: begin
                    inc[CNT_AUX] = 1'b1;
                end
                OP_DROP: begin
                    inc[CNT_DROP] = 1'b1;
                end
                OP_FAIL: begin
                    inc[CNT_FAIL] = 1'b1;
                end
                default: begin
                    inc = '0;
                end
            endcase
        end
    end

    // Advance event counters, wrapping at their width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_CNT; i++) begin
                if (inc[i]) begin
                    r_cnt[i] <= r_cnt[i] + 1'b1;
                end
            end
        end
    end

    // Update latency, first time and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_sum    <= '0;
            r_lat_max    <= '0;
            r_first_mono <= '0;
            r_prev_seq   <= '0;
            r_prev_inc   <= 64'd1;
            r_seq_seen   <= 1'b0;
            r_prev_ts    <= '0;
            r_ts_seen    <= 1'b0;
        end else if (pop) begin
            if (i_cmd.op == OP_PUB) begin
                r_lat_sum <= r_lat_sum + i_cmd.arg;
                if (i_cmd.arg > r_lat_max) begin
                    r_lat_max <= i_cmd.arg;
                end
            end
            if (is_src) begin
                if (i_cmd.arg != '0 && r_first_mono == '0) begin
                    r_first_mono <= i_cmd.arg;
                end
                r_prev_ts <= i_cmd.ts;
                r_ts_seen <= 1'b1;
                if (i_cmd.has_seq) begin
                    r_prev_seq <= i_cmd.seq;
                    r_prev_inc <= i_cmd.seq + 64'd1;
                    r_seq_seen <= (i_cmd.wmode != WM_NONE);
                end
            end
        end
    end

    // Pick the value of the current snapshot slot
    always_comb begin
        case (r_slot)
            IDX_LAT_SUM: slot_value = r_lat_sum;
            IDX_LAT_MAX: slot_value = r_lat_max;
            IDX_START:   slot_value = r_first_mono;
            IDX_END:     slot_value = r_end_time;
            default:     slot_value = 64'(r_cnt[r_slot]);
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequence the snapshot drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (pop && i_cmd.op == OP_SNAP) begin
                        r_state <= ST_DRAIN;
                        r_slot  <= '0;
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        if (r_slot == IDX_END) begin
                            r_state <= ST_IDLE;
                        end
                        r_slot <= r_slot + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Latch the interval end of a snapshot
    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.op == OP_SNAP) begin
            r_end_time <= i_cmd.arg;
        end
    end

    // Load the output register; drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= (r_state == ST_DRAIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_state == ST_DRAIN) begin
            r_out.counter_index <= r_slot;
            r_out.counter_value <= slot_value;
            r_out.last_item     <= (r_slot == IDX_END);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/stream_sequence_and_rate_monitor_core.sv */
// ----------------------------------------------------------------------------
// stream_sequence_and_rate_monitor_core: sequence and rate monitor top level
// Counts stream events, checks sequence numbers and timestamps, tracks
// latency and emits a 15-beat snapshot on request.
//
//   Channel  Direction  Handshake                Beat
//   in       input      i_in_valid/o_in_stall    t_in: one event
//   out      output     o_out_valid/i_out_stall  t_out: one snapshot value
//   cfg      input      i_cfg_we                 i_cfg_wdata: width mode
//
// The front decodes an event in the cycle it is accepted and pushes it into
// a QUEUE_DEPTH entry queue; input stalls only while that queue is full.
// The back executes one non-snapshot event per cycle from the queue while it
// is not draining a snapshot. A snapshot holds the back from the cycle it is
// taken until its last beat leaves the drain state, and output stalls extend
// this. Its first beat passes the queue, drain state and output register.
// Reset is synchronous and clears the counters, latency and history at once.
// ----------------------------------------------------------------------------
module stream_sequence_and_rate_monitor_core
    import ssrm_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata
);

    logic q_full;
    logic q_push;
    t_cmd q_push_cmd;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // Intake and decode
    ssrm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_push_cmd)
    );

    // Decouple front and back
    ssrm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_cmd      (q_cmd),
        .i_pop      (q_pop)
    );

    // Execute and drain snapshots
    ssrm_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* test/stream_sequence_and_rate_monitor_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_sequence_and_rate_monitor_core_tb: self-checking bench for the monitor
// Drives event beats with random gaps and output stalls. A scoreboard class
// tracks counters, latency and sequence/timestamp history, and builds the
// 15 snapshot beats that each snapshot event must produce. Output beats are
// compared in order, field by field. Width mode changes only while idle.
// ----------------------------------------------------------------------------
module stream_sequence_and_rate_monitor_core_tb;
    import ssrm_pkg::*;

    // Unused event code and the width code that behaves like no checking
    localparam logic [2:0] MODE_RESERVED = 3'd7;
    localparam logic [1:0] WM_ALIAS      = 2'd3;
    localparam int         SNAP_BEATS    = 15;
    localparam int         QUIET_CYCLES  = 16;
    localparam int         PHASES        = 8;
    localparam int         PHASE_EVENTS  = 56;

    // ------------------------------------------------------------------------
    // Scoreboard: event statistics and the snapshot beats still owed
    // ------------------------------------------------------------------------
    class snapshot_scoreboard;
        logic [1:0]  width_mode;
        logic [63:0] event_count [NUM_CNT];
        logic [63:0] latency_total;
        logic [63:0] latency_peak;
        logic [63:0] start_time;
        logic [63:0] last_seq;
        logic [63:0] last_ts;
        bit          seq_valid;
        bit          ts_valid;
        t_out        expected_beats [$];
        int          errors;

        function new();
            width_mode    = WM_NONE;
            foreach (event_count[k]) event_count[k] = 64'd0;
            latency_total = 64'd0;
            latency_peak  = 64'd0;
            start_time    = 64'd0;
            last_seq      = 64'd0;
            last_ts       = 64'd0;
            seq_valid     = 1'b0;
            ts_valid      = 1'b0;
            errors        = 0;
        endfunction

        function void bump(logic [3:0] idx);
            event_count[idx] = event_count[idx] + 64'd1;
        endfunction

        function int outstanding();
            return expected_beats.size();
        endfunction

        // Apply one accepted event; queue snapshot beats where due
        function void note_event(t_in ev);
            logic [1:0]  w;
            logic [63:0] cur;
            logic [63:0] succ;
            logic [63:0] v;
            bit          wrapped;
            t_out        beat;
            case (ev.mode)
                MODE_SRC_SEQ, MODE_SRC: begin
                    // first non-zero mono time sticks
                    if (ev.mono_time_ns != 64'd0 && start_time == 64'd0)
                        start_time = ev.mono_time_ns;
                    bump(CNT_SRC);
                    if (ev.mode == MODE_SRC_SEQ) begin
                        w = (width_mode == WM_32 || width_mode == WM_64) ? width_mode : WM_NONE;
                        cur = (w == WM_32) ? {32'd0, ev.seq_number[31:0]} : ev.seq_number;
                        if (w != WM_NONE && seq_valid) begin
                            succ = (w == WM_32) ? {32'd0, last_seq[31:0] + 32'd1}
                                                : last_seq + 64'd1;
                            if (cur == last_seq) begin
                                bump(CNT_SEQ_DUP);
                            end else if (cur != succ) begin
                                // forward 32-bit wrap from upper to lower half is a gap
                                wrapped = (w == WM_32) && (last_seq > {32'd0, HALF32})
                                          && (cur < {32'd0, HALF32});
                                if (cur > succ || wrapped)
                                    bump(CNT_SEQ_GAP);
                                else
                                    bump(CNT_SEQ_REG);
                            end
                        end
                        seq_valid = (w != WM_NONE);
                        last_seq  = cur;
                    end
                    if (ts_valid) begin
                        if (ev.sample_time_ns == last_ts)
                            bump(CNT_TS_DUP);
                        else if (ev.sample_time_ns < last_ts)
                            bump(CNT_TS_REG);
                    end
                    ts_valid = 1'b1;
                    last_ts  = ev.sample_time_ns;
                end
                MODE_PUB_OK: begin
                    bump(CNT_PUB);
                    bump(CNT_LAT);
                    latency_total = latency_total + ev.pub_latency;
                    if (ev.pub_latency > latency_peak)
                        latency_peak = ev.pub_latency;
                end
                MODE_PUB_AUX:  bump(CNT_AUX);
                MODE_DROP:     bump(CNT_DROP);
                MODE_PUB_FAIL: bump(CNT_FAIL);
                MODE_SNAP: begin
                    for (int k = 0; k < SNAP_BEATS; k++) begin
                        if (k < NUM_CNT)
                            v = event_count[k];
                        else if (k == IDX_LAT_SUM)
                            v = latency_total;
                        else if (k == IDX_LAT_MAX)
                            v = latency_peak;
                        else if (k == IDX_START)
                            v = start_time;
                        else
                            v = ev.mono_time_ns;
                        beat.counter_index = k[3:0];
                        beat.counter_value = v;
                        beat.last_item     = (k == IDX_END);
                        expected_beats.push_back(beat);
                    end
                end
                default: ; // reserved code: no effect at all
            endcase
        endfunction

        // Compare one output beat with the oldest expected one
        function void check_beat(t_out got);
            t_out exp_beat;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected output beat index %0d value %h", $time,
                         got.counter_index, got.counter_value);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (got.counter_index !== exp_beat.counter_index) begin
                $display("%0t: counter_index expected %0d got %0d", $time,
                         exp_beat.counter_index, got.counter_index);
                errors++;
            end
            if (got.counter_value !== exp_beat.counter_value) begin
                $display("%0t: counter_value (index %0d) expected %h got %h", $time,
                         exp_beat.counter_index, exp_beat.counter_value, got.counter_value);
                errors++;
            end
            if (got.last_item !== exp_beat.last_item) begin
                $display("%0t: last_item (index %0d) expected %b got %b", $time,
                         exp_beat.counter_index, exp_beat.last_item, got.last_item);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in        i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out       o_out_data;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;
    bit         steady;

    snapshot_scoreboard sb = new();

    stream_sequence_and_rate_monitor_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, a few long; none in steady stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Check every output beat taken
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_beat(o_out_data);
    end

    // Output back-pressure: free runs broken by stalls of random length
    initial begin
        int run;
        i_out_stall = 1'b0;
        forever begin
            run = $urandom_range(1, 20);
            repeat (run) @(negedge i_clk) i_out_stall = 1'b0;
            run = pick_gap();
            repeat (run) @(negedge i_clk) i_out_stall = 1'b1;
        end
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #(20_000_000);
        $display("[stream_sequence_and_rate_monitor_core] ERROR");
        $finish;
    end

    // Present one beat, hold it until taken, then idle for a random gap
    task automatic send_event(input logic [2:0] mode, input logic [63:0] seq,
                              input logic [63:0] ts, input logic [63:0] mono,
                              input logic [63:0] lat);
        t_in beat;
        int  gap;
        beat.mode           = mode;
        beat.seq_number     = seq;
        beat.sample_time_ns = ts;
        beat.mono_time_ns   = mono;
        beat.pub_latency    = lat;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = beat;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_event(beat);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic idle_input();
        @(negedge i_clk) i_in_valid = 1'b0;
    endtask

    // Wait for every owed beat, then let queued non-snapshot events retire
    task automatic drain_pipe();
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [1:0] wm);
        idle_input();
        drain_pipe();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = wm;
        @(posedge i_clk);
        sb.width_mode = wm;
        @(negedge i_clk) i_cfg_we = 1'b0;
    endtask

    // Main flow
    initial begin
        logic [1:0]  phase_width [6];
        logic [1:0]  wm;
        logic [2:0]  mode;
        logic [63:0] gen_seq;
        logic [63:0] gen_ts;
        logic [63:0] seq;
        logic [63:0] ts;
        logic [63:0] mono;
        logic [63:0] lat;
        int          r;
        int          waited;

        phase_width = '{WM_32, WM_64, WM_ALIAS, WM_NONE, WM_32, WM_64};
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = WM_NONE;
        steady      = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // Directed: reset values, zero mono time, timestamp classes, latency wrap
        send_event(MODE_SNAP, 64'd0, 64'd0, '1, 64'd0);
        send_event(MODE_SRC, 64'd0, 64'd100, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd5, 64'd100, 64'h1234, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd5, 64'd50, '1, 64'd0);
        send_event(MODE_PUB_OK, 64'd0, 64'd0, 64'd0, '1);
        send_event(MODE_PUB_OK, 64'd0, 64'd0, 64'd0, 64'd1);
        send_event(MODE_PUB_OK, 64'd0, 64'd0, 64'd0, 64'd0);
        send_event(MODE_PUB_AUX, '1, '1, '1, '1);
        send_event(MODE_DROP, 64'd0, 64'd0, 64'd0, 64'd0);
        send_event(MODE_PUB_FAIL, 64'd0, 64'd0, 64'd0, 64'd0);
        send_event(MODE_RESERVED, '1, 64'd0, 64'd7, '1);
        send_event(MODE_SNAP, 64'd0, 64'd0, 64'd0, 64'd0);

        // Directed: 32-bit successor wrap, duplicate, gap, regression, half wrap
        write_width(WM_32);
        send_event(MODE_SRC_SEQ, 64'hAAAA_BBBB_FFFF_FFFE, 64'd200, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'h0000_0001_FFFF_FFFF, 64'd201, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'h1234_5678_0000_0000, 64'd202, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd0, 64'd203, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd10, 64'd204, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd5, 64'd205, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'hF000_0000, 64'd206, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd3, 64'd207, 64'd0, 64'd0);

        // Directed: 64-bit gap to the top, successor wrap to zero, duplicate
        write_width(WM_64);
        send_event(MODE_SRC_SEQ, '1, 64'd300, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd0, 64'd301, 64'd0, 64'd0);
        send_event(MODE_SRC_SEQ, 64'd0, 64'd302, 64'd0, 64'd0);
        send_event(MODE_SNAP, 64'd0, 64'd0, '1, 64'd0);

        // Random phases, one width mode each; mostly well-formed sequences
        gen_seq = 64'd0;
        gen_ts  = 64'd1000;
        for (int phase = 0; phase < PHASES; phase++) begin
            wm = (phase < 6) ? phase_width[phase] : 2'($urandom_range(0, 3));
            write_width(wm);
            steady = (phase == 2 || phase == 5);
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                // hold off the sender until every owed beat is out
                if (phase == 1 && n == PHASE_EVENTS / 2) begin
                    idle_input();
                    drain_pipe();
                end
                r = $urandom_range(0, 99);
                if (r < 38)       mode = MODE_SRC_SEQ;
                else if (r < 48)  mode = MODE_SRC;
                else if (r < 63)  mode = MODE_PUB_OK;
                else if (r < 68)  mode = MODE_PUB_AUX;
                else if (r < 73)  mode = MODE_DROP;
                else if (r < 78)  mode = MODE_PUB_FAIL;
                else if (r < 81)  mode = MODE_RESERVED;
                else              mode = MODE_SNAP;

                seq = {$urandom, $urandom};
                if (mode == MODE_SRC_SEQ) begin
                    r = $urandom_range(0, 99);
                    if (r < 75)
                        seq = gen_seq + 64'd1;
                    else if (r < 82)
                        seq = gen_seq;
                    else if (r < 88)
                        seq = gen_seq + 64'($urandom_range(2, 1000));
                    else if (r < 93)
                        seq = gen_seq - 64'($urandom_range(1, 50));
                    else if (r < 97)
                        seq = {$urandom, $urandom};
                    else
                        seq = {(wm == WM_64) ? 32'hFFFF_FFFF : 32'($urandom),
                               28'hFFF_FFFF, 4'($urandom)};
                    // upper half is dropped at 32 bits: keep it busy
                    if (wm == WM_32)
                        seq[63:32] = $urandom;
                    gen_seq = seq;
                end

                r = $urandom_range(0, 99);
                if (r < 85)
                    ts = gen_ts + 64'($urandom_range(1, 1000));
                else if (r < 92)
                    ts = gen_ts;
                else if (r < 97)
                    ts = gen_ts - 64'($urandom_range(1, 1000));
                else
                    ts = {$urandom, $urandom};
                if (mode == MODE_SRC_SEQ || mode == MODE_SRC)
                    gen_ts = ts;

                r = $urandom_range(0, 99);
                if (r < 10)
                    mono = 64'd0;
                else if (r < 30)
                    mono = {$urandom, $urandom};
                else
                    mono = 64'($urandom);

                if ($urandom_range(0, 99) < 70)
                    lat = 64'($urandom_range(0, 100000));
                else
                    lat = {$urandom, $urandom};

                send_event(mode, seq, ts, mono, lat);
            end
        end

        // Close out: final snapshot, drain, settle
        send_event(MODE_SNAP, 64'd0, 64'd0, '1, 64'd0);
        idle_input();
        for (waited = 0; waited < 20000 && sb.outstanding() != 0; waited++)
            @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $display("%0t: %0d snapshot beats never arrived", $time, sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("[stream_sequence_and_rate_monitor_core] OK");
        else
            $display("[stream_sequence_and_rate_monitor_core] ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ssrm_pkg.sv
rtl/core/ssrm_front.sv
rtl/core/ssrm_queue.sv
rtl/core/ssrm_back.sv
rtl/core/stream_sequence_and_rate_monitor_core.sv
test/stream_sequence_and_rate_monitor_core_tb.sv
